[rtl/incidence_inverter_defines.svh]
// Assertion helpers for the RTL.
`ifndef INCIDENCE_INVERTER_DEFINES_SVH
`define INCIDENCE_INVERTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define IINV_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("iinv check failed");

// Next-cycle implication, disabled while in reset.
`define IINV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("iinv check failed");

`endif

[rtl/iinv_pkg.sv]
`timescale 1ns / 1ps
package iinv_pkg;

	localparam int NUM_VERTICES = 1024;
	localparam int MAX_VALENCE  = 32;
	localparam int ELEMENT_BITS = 16;

	localparam int VIDX_W      = $clog2(NUM_VERTICES);
	localparam int SLOT_W      = $clog2(MAX_VALENCE);
	localparam int FILL_W      = $clog2(MAX_VALENCE + 1);
	localparam int ADDR_W      = VIDX_W + SLOT_W;
	localparam int STORE_DEPTH = NUM_VERTICES * MAX_VALENCE;

	localparam int VCNT_W = 11;
	localparam int ELEM_W = 16;
	localparam int VAL_W  = 6;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 11'd1024;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [VCNT_W-1:0]  vertex;
		logic [ELEM_W-1:0]  element;
	} req_t;

	typedef struct packed {
		logic [ELEM_W-1:0]  element_out;
		status_t            status;
		logic [VAL_W-1:0]   valence;
		logic               last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic app_exec;
		logic q_check;
		logic q_issue;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic range_ok;
		logic fill_zero;
		logic clr_last;
		logic k_last;
	} sts_t;

endpackage

[rtl/iinv_ram.sv]
`timescale 1ns / 1ps
module iinv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/iinv_ctrl.sv]
`timescale 1ns / 1ps
module iinv_ctrl import iinv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  kind_t kind,
	input  sts_t  sts,
	output cmd_t  cmd,
	output logic  busy
);

	typedef enum logic [5:0] {
		S_CLR   = 6'b000001,
		S_IDLE  = 6'b000010,
		S_APP   = 6'b000100,
		S_QFILL = 6'b001000,
		S_QRUN  = 6'b010000,
		S_QTAIL = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					unique case (kind)
						KIND_APPEND: state_d = S_APP;
						KIND_QUERY:  state_d = S_QFILL;
						KIND_CLEAR:  state_d = S_CLR;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_APP: begin
				cmd.app_exec = 1'b1;
				state_d      = S_IDLE;
			end
			S_QFILL: begin
				cmd.q_check = 1'b1;
				if (sts.range_ok && !sts.fill_zero) begin
					state_d = S_QRUN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_QRUN: begin
				cmd.q_issue = 1'b1;
				if (sts.k_last) begin
					state_d = S_QTAIL;
				end
			end
			S_QTAIL: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[rtl/iinv_dp.sv]
`timescale 1ns / 1ps
`include "incidence_inverter_defines.svh"
module iinv_dp import iinv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  logic              cfg_we,
	input  logic [VCNT_W-1:0] cfg_wdata,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic              result_valid,
	output result_t           result
);

	logic [VCNT_W-1:0]       vcnt_q;
	logic [VCNT_W-1:0]       limit;
	logic                    in_range;
	logic [VIDX_W-1:0]       idx_in;

	logic [VIDX_W-1:0]       idx_q;
	logic [ELEMENT_BITS-1:0] elem_q;
	logic                    range_ok_q;

	logic [VIDX_W-1:0]       clr_cnt_q;
	logic                    clr_last;

	logic                    fill_we;
	logic [VIDX_W-1:0]       fill_waddr;
	logic [FILL_W-1:0]       fill_wdata;
	logic [FILL_W-1:0]       fill_rd;
	logic                    fill_full;
	logic                    app_write;

	logic [ADDR_W-1:0]       store_waddr;
	logic [ADDR_W-1:0]       store_raddr;
	logic [ELEMENT_BITS-1:0] store_rd;

	logic [FILL_W-1:0]       fill_q;
	logic [SLOT_W-1:0]       k_q;
	logic                    k_last;
	logic                    rd_v_s1;
	logic                    last_s1;

	logic                    res_v_d;
	result_t                 res_d;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= VCNT_RESET;
		end else if (cfg_we) begin
			vcnt_q <= cfg_wdata;
		end
	end

	assign limit    = (vcnt_q > VCNT_W'(NUM_VERTICES)) ? VCNT_W'(NUM_VERTICES) : vcnt_q;
	assign in_range = (req.vertex != '0) && (req.vertex <= limit);
	assign idx_in   = VIDX_W'(req.vertex - VCNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q      <= idx_in;
			elem_q     <= req.element[ELEMENT_BITS-1:0];
			range_ok_q <= in_range;
		end
	end

	// clear sweep counter
	assign clr_last = (clr_cnt_q == VIDX_W'(NUM_VERTICES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_last ? '0 : clr_cnt_q + VIDX_W'(1);
		end
	end

	// fill counters
	assign fill_full  = (fill_rd >= FILL_W'(MAX_VALENCE));
	assign app_write  = cmd.app_exec && range_ok_q && !fill_full;
	assign fill_we    = cmd.clr_wr || app_write;
	assign fill_waddr = cmd.clr_wr ? clr_cnt_q : idx_q;
	assign fill_wdata = cmd.clr_wr ? '0 : fill_rd + FILL_W'(1);

	iinv_ram #(
		.WIDTH (FILL_W),
		.DEPTH (NUM_VERTICES)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (idx_in),
		.rdata (fill_rd)
	);

	// bucket entries
	assign store_waddr = {idx_q, fill_rd[SLOT_W-1:0]};
	assign store_raddr = {idx_q, k_q};

	iinv_ram #(
		.WIDTH (ELEMENT_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store_ram (
		.clk   (clk),
		.we    (app_write),
		.waddr (store_waddr),
		.wdata (elem_q),
		.raddr (store_raddr),
		.rdata (store_rd)
	);

	// query walk
	assign k_last = ((FILL_W'(k_q) + FILL_W'(1)) == fill_q);

	always_ff @(posedge clk) begin
		if (cmd.q_check) begin
			fill_q <= fill_rd;
			k_q    <= '0;
		end else if (cmd.q_issue) begin
			k_q <= k_q + SLOT_W'(1);
		end
		last_s1 <= k_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.q_issue;
		end
	end

	// result select
	always_comb begin
		res_v_d          = 1'b0;
		res_d            = '0;
		res_d.status     = ST_OK;
		res_d.last       = 1'b1;
		if (rd_v_s1) begin
			res_v_d           = 1'b1;
			res_d.element_out = ELEM_W'(store_rd);
			res_d.valence     = VAL_W'(fill_q);
			res_d.last        = last_s1;
		end else if (cmd.app_exec) begin
			res_v_d = 1'b1;
			if (!range_ok_q) begin
				res_d.status = ST_RANGE;
			end else if (fill_full) begin
				res_d.status  = ST_FULL;
				res_d.valence = VAL_W'(fill_rd);
			end else begin
				res_d.element_out = ELEM_W'(elem_q);
				res_d.valence     = VAL_W'(fill_rd + FILL_W'(1));
			end
		end else if (cmd.q_check) begin
			if (!range_ok_q) begin
				res_v_d      = 1'b1;
				res_d.status = ST_RANGE;
			end else if (fill_rd == '0) begin
				res_v_d      = 1'b1;
				res_d.status = ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= res_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (res_v_d) begin
			result <= res_d;
		end
	end

	assign sts.range_ok  = range_ok_q;
	assign sts.fill_zero = (fill_rd == '0);
	assign sts.clr_last  = clr_last;
	assign sts.k_last    = k_last;

	`IINV_ASSERT_NOW(a_fill_bound, clk, arst_n, fill_we, fill_wdata <= FILL_W'(MAX_VALENCE))
	`IINV_ASSERT_NEXT(a_walk_emits, clk, arst_n, rd_v_s1, result_valid && result.status == ST_OK)
	`IINV_ASSERT_NOW(a_ok_has_val, clk, arst_n, result_valid && result.status == ST_OK, result.valence != '0)
	`IINV_ASSERT_NOW(a_err_is_last, clk, arst_n, result_valid && result.status != ST_OK, result.last)

endmodule

[rtl/incidence_inverter.sv]
`timescale 1ns / 1ps
// Per-vertex element buckets. A request is taken when start is high and busy is low.
// An append reads the fill counter, then writes it; a query reads the fill counter, then
// reads one entry per cycle from the bucket RAM, then drains, or stops after the fill
// check when the bucket is empty or the vertex is out of range; a clear is accepted, then
// zeroes one fill counter per cycle; after reset a clearing pass over every fill counter
// runs with busy high, while vertex_count writes are taken as ever.
// Each result shows on result for exactly one cycle with result_valid high; there is
// no backpressure, so the receiver must take every result as it comes.
module incidence_inverter import iinv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	input  logic              cfg_we,
	input  logic [VCNT_W-1:0] cfg_wdata,
	output logic              result_valid,
	output result_t           result
);

	cmd_t cmd;
	sts_t sts;

	iinv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	iinv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
import iinv_pkg::*;

class incidence_tracker;
	logic [ELEM_W-1:0] entries [NUM_VERTICES][MAX_VALENCE];
	int unsigned fill [NUM_VERTICES];
	logic [VCNT_W-1:0] vertex_count;
	result_t pending [$];
	int errors;

	function new();
		vertex_count = VCNT_RESET;
		foreach (fill[i]) fill[i] = 0;
		errors = 0;
	endfunction

	function void set_vertex_count(input logic [VCNT_W-1:0] v);
		vertex_count = v;
	endfunction

	function void expect_result(input result_t res);
		pending.insert(pending.size(), res);
	endfunction

	function void take_request(input req_t r);
		result_t res;
		int unsigned lim;
		int unsigned idx;
		int unsigned k;
		lim = (vertex_count > NUM_VERTICES) ? NUM_VERTICES : vertex_count;
		res = '0;
		res.last = 1'b1;
		case (r.kind)
			KIND_CLEAR: begin
				foreach (fill[i]) fill[i] = 0;
			end
			KIND_APPEND, KIND_QUERY: begin
				if (r.vertex == 0 || r.vertex > lim) begin
					res.status = ST_RANGE;
					expect_result(res);
				end else begin
					idx = r.vertex - 1;
					if (r.kind == KIND_APPEND) begin
						if (fill[idx] >= MAX_VALENCE) begin
							res.status = ST_FULL;
							res.valence = VAL_W'(fill[idx]);
						end else begin
							entries[idx][fill[idx]] = r.element;
							fill[idx]++;
							res.status = ST_OK;
							res.element_out = r.element;
							res.valence = VAL_W'(fill[idx]);
						end
						expect_result(res);
					end else if (fill[idx] == 0) begin
						res.status = ST_EMPTY;
						expect_result(res);
					end else begin
						for (k = 0; k < fill[idx]; k++) begin
							res.status = ST_OK;
							res.element_out = entries[idx][k];
							res.valence = VAL_W'(fill[idx]);
							res.last = (k + 1 == fill[idx]);
							expect_result(res);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(input result_t got);
		result_t exp;
		if (pending.size() == 0) begin
			$error("result with none expected: element_out %h status %0d valence %0d last %0d",
				got.element_out, got.status, got.valence, got.last);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.element_out !== exp.element_out) begin
			$error("element_out: expected %h, got %h", exp.element_out, got.element_out);
			errors++;
		end
		if (got.status !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, got.status);
			errors++;
		end
		if (got.valence !== exp.valence) begin
			$error("valence: expected %0d, got %0d", exp.valence, got.valence);
			errors++;
		end
		if (got.last !== exp.last) begin
			$error("last: expected %0d, got %0d", exp.last, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam kind_t KIND_UNUSED = kind_t'(2'd3);
	localparam int CLEAR_CYCLES = 1100;
	localparam int WATCHDOG_LIMIT = 12000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic cfg_we = 1'b0;
	logic [VCNT_W-1:0] cfg_wdata = '0;
	logic busy;
	logic result_valid;
	result_t result;

	incidence_tracker tracker;
	int items_sent = 0;
	int idle_pct = 0;
	int unsigned cur_limit = NUM_VERTICES;
	int idle_cycles = 0;

	logic [VCNT_W-1:0] phase_vcount [6] = '{11'd2, 11'd0, 11'd2047, 11'd1, 11'd5, 11'd1024};
	int phase_idle [3] = '{0, 47, 13};

	incidence_inverter uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.result(result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) tracker.check_result(result);
			if (start && !busy) tracker.take_request(req);
			if (result_valid || (start && !busy)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send(input kind_t k, input logic [VCNT_W-1:0] v,
			input logic [ELEM_W-1:0] e);
		req_t r;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		r.kind = k;
		r.vertex = v;
		r.element = e;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (k != KIND_UNUSED) items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	// a clear or the post-reset pass produces nothing, so wait it out
	task automatic write_vertex_count(input logic [VCNT_W-1:0] v);
		drain();
		repeat (CLEAR_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_vertex_count(v);
		cur_limit = (v > NUM_VERTICES) ? NUM_VERTICES : v;
	endtask

	function automatic logic [VCNT_W-1:0] pick_vertex();
		int unsigned r;
		r = $urandom_range(9);
		if (cur_limit == 0) return VCNT_W'($urandom_range(0, 3));
		case (r)
			0, 1, 2, 3, 4, 5: return VCNT_W'($urandom_range(1, (cur_limit < 4) ? cur_limit : 4));
			6: return VCNT_W'(cur_limit);
			7: return VCNT_W'((cur_limit > 1) ? cur_limit - 1 : 1);
			8: return ($urandom_range(1) != 0) ? VCNT_W'(0) : VCNT_W'(cur_limit + 1);
			default: return VCNT_W'($urandom_range(0, 2047));
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] rand_element();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return ELEM_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic fill_bucket(input logic [VCNT_W-1:0] v);
		int n;
		n = $urandom_range(33, 36);
		repeat (n) send(KIND_APPEND, v, rand_element());
		send(KIND_QUERY, v, rand_element());
	endtask

	task automatic run_random(input int n);
		int goal;
		int unsigned pick;
		logic [VCNT_W-1:0] v;
		goal = items_sent + n;
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			v = pick_vertex();
			if (pick < 60) send(KIND_APPEND, v, rand_element());
			else if (pick < 88) send(KIND_QUERY, v, rand_element());
			else if (pick < 91) send(KIND_CLEAR, v, rand_element());
			else if (pick < 96) send(KIND_UNUSED, v, rand_element());
			else drain();
		end
	endtask

	initial begin
		int p;
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_vertex_count(VCNT_RESET);

		send(KIND_APPEND, 11'd1, 16'h0000);
		send(KIND_APPEND, 11'd1, 16'hFFFF);
		send(KIND_APPEND, 11'd1024, 16'hA5A5);
		send(KIND_APPEND, 11'd0, 16'h1234);
		send(KIND_APPEND, 11'd1025, 16'h5A5A);
		send(KIND_APPEND, 11'd2047, 16'hFFFF);
		send(KIND_QUERY, 11'd1, 16'h0000);
		send(KIND_QUERY, 11'd1024, 16'h0000);
		send(KIND_QUERY, 11'd7, 16'hFFFF);
		send(KIND_QUERY, 11'd0, 16'h0000);
		send(KIND_QUERY, 11'd1025, 16'h0000);
		send(KIND_UNUSED, 11'd2047, 16'hFFFF);
		send(KIND_QUERY, 11'd1, 16'h0000);
		send(KIND_CLEAR, 11'd0, 16'h0000);
		send(KIND_QUERY, 11'd1, 16'h0000);
		send(KIND_QUERY, 11'd1024, 16'h0000);
		send(KIND_APPEND, 11'd512, 16'h8001);
		send(KIND_QUERY, 11'd512, 16'h0000);

		for (p = 0; p < 6; p++) begin
			write_vertex_count(phase_vcount[p]);
			idle_pct = phase_idle[p % 3];
			if (p == 2 || p == 4) fill_bucket(VCNT_W'(cur_limit));
			run_random((phase_vcount[p] == 0) ? 8 : 12);
		end

		drain();
		repeat (CLEAR_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/iinv_pkg.sv
rtl/iinv_ram.sv
rtl/iinv_ctrl.sv
rtl/iinv_dp.sv
rtl/incidence_inverter.sv
tb/sv/testbench.sv
